### src/ss_pkg.sv
// Shared types, codes and size constants for the subsequence search block.
package ss_pkg;

    // Field widths of the transactions.
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = 4;
    localparam int POS_W     = 16;
    localparam int LEN_CFG_W = 5;

    // Default sizes handed down from the top level.
    localparam int              MAX_PATTERN_DEF = 16;
    localparam longint unsigned MAX_TEXT_DEF    = 64'd65536;
    localparam int              QUEUE_DEPTH_DEF = 4;

    // Operation codes of an input transaction.
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // Command kinds after classification in the front end.
    localparam logic [1:0] CMD_NOP     = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic                     operation;
        logic [SLOT_W-1:0]        slot;
        logic signed [WORD_W-1:0] word;
        logic                     final_word;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } out_item_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic              last;
    } cmd_t;

endpackage

### src/ss_front.sv
// Front end: accepts input transactions, classifies them and feeds the command queue.
module ss_front
    import ss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    output logic     push,
    input  logic     queue_full,
    output cmd_t     cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    // The stage holds its command until the queue has room for it.
    assign item_stall = valid_reg && queue_full;
    assign accept     = item_valid && !item_stall;
    assign push       = valid_reg && !queue_full;
    assign cmd        = cmd_reg;

    // Decode the operation; pattern writes to slots beyond the store become no-ops.
    always_comb
    begin
        cmd_next.slot = item.slot;
        cmd_next.word = item.word;
        cmd_next.last = item.final_word;
        case (item.operation)
            OP_PATTERN:
            begin
                if (int'(item.slot) < MAX_PATTERN)
                    cmd_next.kind = CMD_PATTERN;
                else
                    cmd_next.kind = CMD_NOP;
            end
            OP_TEXT:
            begin
                cmd_next.kind = CMD_TEXT;
            end
            default:
            begin
                cmd_next.kind = CMD_NOP;
            end
        endcase
    end

    // Occupancy of the stage.
    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

### src/ss_queue.sv
// Short show-ahead command queue between the front end and the back end.
module ss_queue
    import ss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    // Pointer wrap and occupancy count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_cmd;
    end

endmodule

### src/ss_back.sv
// Back end: pattern stores, text window, parallel compare and result register.
module ss_back
    import ss_pkg::*;
#(
    parameter int              MAX_PATTERN = MAX_PATTERN_DEF,
    parameter longint unsigned MAX_TEXT    = MAX_TEXT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [LEN_CFG_W-1:0] cfg_data,
    input  logic                 head_valid,
    input  cmd_t                 head,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_item_t            result
);

    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W  = $clog2(MAX_TEXT + 2);
    localparam int CALC_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;
    localparam logic [CNT_W-1:0] TEXT_LIMIT = CNT_W'(MAX_TEXT);

    // Pattern as written by slot, and the same pattern aligned to the window
    // so that window entry k meets pattern slot len-1-k at entry k.
    logic [WORD_W-1:0] plain_reg   [MAX_PATTERN];
    logic [WORD_W-1:0] aligned_reg [MAX_PATTERN];
    logic [WORD_W-1:0] win_reg     [MAX_PATTERN];
    logic [WORD_W-1:0] win_next    [MAX_PATTERN];

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_cfg;
    logic              sweep_reg;
    logic [IDX_W-1:0]  sweep_idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              reported_reg;
    logic              reported_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_reg;
    out_item_t         out_next;

    logic              is_text;
    logic              is_pattern;
    logic              search;
    logic              in_range;
    logic              equal;
    logic              produce;
    logic [MAX_PATTERN-1:0] hit;
    logic [CALC_W-1:0] count_inc;
    logic [CALC_W-1:0] start_pos;
    logic [IDX_W-1:0]  slot_idx;
    logic [IDX_W-1:0]  aligned_idx;
    logic [IDX_W-1:0]  sweep_src;

    // A command retires when no realignment sweep runs and the result register is free or drains this cycle.
    assign pop          = head_valid && !sweep_reg && (!out_valid_reg || !result_stall);
    assign is_text      = pop && (head.kind == CMD_TEXT);
    assign is_pattern   = pop && (head.kind == CMD_PATTERN);
    assign search       = is_text && !reported_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Clamp the configured length into the range the store supports.
    always_comb
    begin
        if (cfg_data == '0)
            len_cfg = LEN_W'(1);
        else if (int'(cfg_data) > MAX_PATTERN)
            len_cfg = LEN_W'(MAX_PATTERN);
        else
            len_cfg = LEN_W'(cfg_data);
    end

    // Store addresses for pattern writes and for the realignment sweep.
    assign slot_idx    = IDX_W'(head.slot);
    assign aligned_idx = IDX_W'(int'(len_reg) - 1 - int'(head.slot));
    assign sweep_src   = IDX_W'(int'(len_reg) - 1 - int'(sweep_idx_reg));

    // Window after this text word shifts in, newest at entry 0.
    always_comb
    begin
        win_next[0] = head.word;
        for (int k = 1; k < MAX_PATTERN; k++)
            win_next[k] = win_reg[k - 1];
    end

    // Parallel compare of the used window entries against the aligned pattern.
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
            hit[k] = (k >= int'(len_reg)) || (win_next[k] == aligned_reg[k]);
        equal = &hit;
    end

    // A match needs a full pattern of text inside the counted range.
    assign count_inc = CALC_W'(count_reg) + CALC_W'(1);
    assign start_pos = count_inc - CALC_W'(len_reg);
    assign in_range  = (count_reg < TEXT_LIMIT) && (count_inc >= CALC_W'(len_reg));

    // Search bookkeeping and result selection.
    always_comb
    begin
        count_next        = count_reg;
        reported_next     = reported_reg;
        produce           = 1'b0;
        out_next.found    = 1'b0;
        out_next.position = '0;
        if (search)
        begin
            if (count_reg <= TEXT_LIMIT)
                count_next = count_reg + 1'b1;
            if (in_range && equal)
            begin
                produce           = 1'b1;
                reported_next     = 1'b1;
                out_next.found    = 1'b1;
                out_next.position = start_pos[POS_W-1:0];
            end
            else if (head.last)
            begin
                produce = 1'b1;
            end
        end
        if (is_text && head.last)
        begin
            count_next    = '0;
            reported_next = 1'b0;
        end
    end

    // The result register empties when taken and refills from a retiring command.
    always_comb
    begin
        if (produce)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state and pattern stores; a length write realigns the pattern
    // slot by slot over the used slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_W'(1);
            sweep_reg     <= 1'b0;
            sweep_idx_reg <= '0;
            count_reg     <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                plain_reg[k]   <= '0;
                aligned_reg[k] <= '0;
            end
        end
        else
        begin
            count_reg     <= count_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                len_reg       <= len_cfg;
                sweep_reg     <= 1'b1;
                sweep_idx_reg <= '0;
            end
            else if (sweep_reg)
            begin
                aligned_reg[sweep_idx_reg] <= plain_reg[sweep_src];
                if (int'(sweep_idx_reg) == int'(len_reg) - 1)
                    sweep_reg <= 1'b0;
                else
                    sweep_idx_reg <= sweep_idx_reg + 1'b1;
            end
            if (is_pattern)
            begin
                plain_reg[slot_idx] <= head.word;
                if (int'(head.slot) < int'(len_reg))
                    aligned_reg[aligned_idx] <= head.word;
            end
        end
    end

    // Text window and result payload.
    always_ff @(posedge clk)
    begin
        if (search)
            win_reg <= win_next;
        if (produce)
            out_reg <= out_next;
    end

endmodule

### src/subsequence_search_top.sv
// Top level of the subsequence search: front end, command queue and back end.
// A result passes through the front-end command register, the command queue and the result register.
// Throughput: one transaction per cycle unless a sweep or result_stall holds the queue.
// After each pattern_length write the back end realigns the pattern one used slot at a time,
// during which queued transactions wait.
// Reset (rst_n, asynchronous) clears the pattern, the search and sets pattern_length to 1.
module subsequence_search_top
    import ss_pkg::*;
#(
    parameter int              MAX_PATTERN = MAX_PATTERN_DEF,
    parameter longint unsigned MAX_TEXT    = MAX_TEXT_DEF,
    parameter int              QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  in_item_t             item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_item_t            result,
    input  logic                 cfg_we,
    input  logic [LEN_CFG_W-1:0] cfg_data
);

    logic push;
    logic queue_full;
    logic queue_not_empty;
    logic pop;
    cmd_t front_cmd;
    cmd_t head;

    // Accept and classify input transactions.
    ss_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .queue_full (queue_full),
        .cmd        (front_cmd)
    );

    // Decouple the two halves.
    ss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // Execute commands and hold results.
    ss_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .head_valid   (queue_not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
